/* hw/rtl/pld_pkg.sv */
// Package for the posting list decoder: payload types, codes and sizing constants.
package pld_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 24;
  localparam int unsigned ValW  = 32;
  localparam int unsigned DocW  = 32;

  // Varint framing.
  localparam int unsigned MoreBit        = 7;
  localparam int unsigned PayloadW       = 7;
  localparam int unsigned AccW           = 64;
  localparam int unsigned IdxW           = 4;
  localparam int unsigned ShamtW         = 6;
  localparam logic [IdxW-1:0] MaxVarintBytes = IdxW'(10);

  // Queue sizes.
  localparam int unsigned TokDepth = 4;
  localparam int unsigned TokPtrW  = $clog2(TokDepth);
  localparam int unsigned TokCntW  = $clog2(TokDepth + 1);
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);
  localparam int unsigned ResPerTok = 2;

  typedef enum logic [1:0] {
    KindPosting  = 2'd0,
    KindPosition = 2'd1,
    KindOk       = 2'd2,
    KindError    = 2'd3
  } pld_kind_e;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrTrunc = 2'd1,
    ErrLong  = 2'd2,
    ErrCount = 2'd3
  } pld_err_e;

  typedef enum logic [1:0] {
    TokVarint   = 2'd0,
    TokTrunc    = 2'd1,
    TokOverlong = 2'd2
  } pld_tok_e;

  typedef enum logic [2:0] {
    PhCount  = 3'd0,
    PhDoc    = 3'd1,
    PhTf     = 3'd2,
    PhPcount = 3'd3,
    PhPos    = 3'd4,
    PhDone   = 3'd5
  } pld_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  bytes_left;
  } pld_in_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [DocW-1:0] doc_id;
    logic [ValW-1:0] term_freq;
    logic [LenW-1:0] pos_count;
    logic [ValW-1:0] position;
    logic [1:0]      error_code;
  } pld_out_t;

  // One classified event from the byte front end.
  typedef struct packed {
    pld_tok_e        kind;
    logic [ValW-1:0] value;
    logic            gt_left;
    logic            last;
  } pld_tok_t;

endpackage

/* hw/rtl/pld_front.sv */
// Front end: assembles varints from bytes and classifies each completed field.
module pld_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pld_pkg::pld_in_t   in_data_i,
  input  logic               tok_full_i,
  output logic               tok_push_o,
  output pld_pkg::pld_tok_t  tok_o
);
  import pld_pkg::*;

  logic [ValW-1:0]   acc_q, acc_d, acc_new;
  logic              hi_q, hi_d, hi_new;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ShamtW-1:0] shamt;
  logic [AccW-1:0]   shifted;
  logic              accept, last, gt;

  assign in_stall_o = tok_full_i;
  assign accept     = in_valid_i & ~tok_full_i;
  assign last       = (in_data_i.bytes_left == '0);

  assign shamt   = ShamtW'(idx_q) * ShamtW'(PayloadW);
  assign shifted = {{(AccW-PayloadW){1'b0}}, in_data_i.data_byte[PayloadW-1:0]} << shamt;
  assign acc_new = acc_q | shifted[ValW-1:0];
  assign hi_new  = hi_q | (|shifted[AccW-1:ValW]);
  // Anything at bit 24 or above already exceeds every possible byte count.
  assign gt      = hi_new | (|acc_new[ValW-1:LenW]) | (acc_new[LenW-1:0] > in_data_i.bytes_left);

  always_comb begin
    acc_d      = acc_q;
    hi_d       = hi_q;
    idx_d      = idx_q;
    tok_push_o = 1'b0;
    tok_o.kind    = TokVarint;
    tok_o.value   = acc_new;
    tok_o.gt_left = gt;
    tok_o.last    = last;
    if (accept) begin
      if (idx_q >= MaxVarintBytes) begin
        tok_push_o = 1'b1;
        tok_o.kind = TokOverlong;
      end else if (in_data_i.data_byte[MoreBit]) begin
        acc_d = acc_new;
        hi_d  = hi_new;
        idx_d = idx_q + IdxW'(1);
        if (last) begin
          tok_push_o = 1'b1;
          tok_o.kind = TokTrunc;
        end
      end else begin
        tok_push_o = 1'b1;
        acc_d = '0;
        hi_d  = 1'b0;
        idx_d = '0;
      end
      // The end of a buffer always starts the next list from scratch.
      if (last) begin
        acc_d = '0;
        hi_d  = 1'b0;
        idx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      hi_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      acc_q <= acc_d;
      hi_q  <= hi_d;
      idx_q <= idx_d;
    end
  end

endmodule

/* hw/rtl/pld_tok_fifo.sv */
// Short queue of classified field events between the front end and the sequencer.
module pld_tok_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pld_pkg::pld_tok_t  data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pld_pkg::pld_tok_t  data_o
);
  import pld_pkg::*;

  pld_tok_t           mem_q [TokDepth];
  logic [TokPtrW-1:0] wr_q, rd_q;
  logic [TokCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == TokCntW'(TokDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + TokPtrW'(1);
      if (do_pop)  rd_q <= rd_q + TokPtrW'(1);
      cnt_q <= cnt_q + TokCntW'(do_push) - TokCntW'(do_pop);
    end
  end

endmodule

/* hw/rtl/pld_back.sv */
// Back end: field sequencer that rebuilds ids and positions and queues result beats.
module pld_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  pld_pkg::pld_tok_t  tok_i,
  output logic               tok_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pld_pkg::pld_out_t  out_data_o
);
  import pld_pkg::*;

  pld_phase_e      phase_q, phase_d;
  logic [LenW-1:0] postings_q, postings_d, positions_q, positions_d;
  logic [DocW-1:0] prev_doc_q, prev_doc_d;
  logic [ValW-1:0] prev_pos_q, prev_pos_d, tf_q, tf_d;

  pld_out_t           res_q [ResDepth];
  logic [ResPtrW-1:0] res_wr_q, res_rd_q;
  logic [ResCntW-1:0] res_cnt_q;

  logic            take, pop;
  logic            rec_valid, fin_valid, ended;
  pld_out_t        rec, fin_rec, res_a;
  logic [1:0]      n_res;
  logic [LenW-1:0] val24, pos_left, post_left;
  logic [ValW-1:0] pos_new;

  // A token is taken only when both of its possible result beats fit.
  assign take        = tok_valid_i & (res_cnt_q <= ResCntW'(ResDepth - ResPerTok));
  assign tok_pop_o   = take;
  assign out_valid_o = (res_cnt_q != '0);
  assign out_data_o  = res_q[res_rd_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign val24       = tok_i.value[LenW-1:0];
  assign pos_left    = positions_q - LenW'(1);
  assign post_left   = postings_q - LenW'(1);
  assign pos_new     = prev_pos_q + tok_i.value;

  always_comb begin
    phase_d     = phase_q;
    postings_d  = postings_q;
    positions_d = positions_q;
    prev_doc_d  = prev_doc_q;
    prev_pos_d  = prev_pos_q;
    tf_d        = tf_q;
    rec_valid   = 1'b0;
    rec         = '0;
    fin_valid   = 1'b0;
    fin_rec     = '0;
    ended       = 1'b0;
    if (take) begin
      if (phase_q == PhDone) begin
        if (tok_i.last) phase_d = PhCount;
      end else begin
        case (tok_i.kind)
          TokOverlong: begin
            fin_valid = 1'b1;
            fin_rec.kind = KindError;
            fin_rec.error_code = ErrLong;
          end
          TokTrunc: begin
            fin_valid = 1'b1;
            fin_rec.kind = KindError;
            fin_rec.error_code = ErrTrunc;
          end
          TokVarint: begin
            case (phase_q)
              PhCount: begin
                if (tok_i.gt_left) begin
                  fin_valid = 1'b1;
                  fin_rec.kind = KindError;
                  fin_rec.error_code = ErrCount;
                end else begin
                  postings_d = val24;
                  prev_doc_d = '0;
                  if (val24 == '0) begin
                    fin_valid = 1'b1;
                    fin_rec.kind = KindOk;
                  end else begin
                    phase_d = PhDoc;
                  end
                end
              end
              PhDoc: begin
                prev_doc_d = prev_doc_q + DocW'(tok_i.value);
                phase_d = PhTf;
              end
              PhTf: begin
                tf_d = tok_i.value;
                phase_d = PhPcount;
              end
              PhPcount: begin
                if (tok_i.gt_left) begin
                  fin_valid = 1'b1;
                  fin_rec.kind = KindError;
                  fin_rec.error_code = ErrCount;
                end else begin
                  positions_d = val24;
                  prev_pos_d  = '0;
                  rec_valid   = 1'b1;
                  rec.kind      = KindPosting;
                  rec.doc_id    = prev_doc_q;
                  rec.term_freq = tf_q;
                  rec.pos_count = val24;
                  if (val24 == '0) ended = 1'b1;
                  else phase_d = PhPos;
                end
              end
              PhPos: begin
                prev_pos_d  = pos_new;
                positions_d = pos_left;
                rec_valid   = 1'b1;
                rec.kind      = KindPosition;
                rec.doc_id    = prev_doc_q;
                rec.term_freq = tf_q;
                rec.pos_count = pos_left;
                rec.position  = pos_new;
                if (pos_left == '0) ended = 1'b1;
              end
              default: begin
                phase_d = PhCount;
              end
            endcase
            if (ended) begin
              postings_d = post_left;
              if (post_left == '0) begin
                fin_valid = 1'b1;
                fin_rec.kind = KindOk;
              end else begin
                phase_d = PhDoc;
              end
            end
            // The buffer ran out while more fields were still expected.
            if (!fin_valid && tok_i.last) begin
              fin_valid = 1'b1;
              fin_rec.kind = KindError;
              fin_rec.error_code = ErrTrunc;
            end
          end
          default: begin
            phase_d = PhCount;
          end
        endcase
        if (fin_valid) begin
          phase_d = tok_i.last ? PhCount : PhDone;
        end
      end
    end
    res_a = rec_valid ? rec : fin_rec;
    n_res = {1'b0, rec_valid} + {1'b0, fin_valid};
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) res_q[res_wr_q] <= res_a;
    if (n_res == 2'd2) res_q[res_wr_q + ResPtrW'(1)] <= fin_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhCount;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      res_wr_q  <= res_wr_q + ResPtrW'(n_res);
      if (pop) res_rd_q <= res_rd_q + ResPtrW'(1);
      res_cnt_q <= res_cnt_q + ResCntW'(n_res) - ResCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    postings_q  <= postings_d;
    positions_q <= positions_d;
    prev_doc_q  <= prev_doc_d;
    prev_pos_q  <= prev_pos_d;
    tf_q        <= tf_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && tok_i.last |=> phase_q == PhCount)
    else $error("sequencer did not rearm at end of buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && phase_q == PhDone |-> n_res == 2'd0)
    else $error("result produced after list completion");

endmodule

/* hw/rtl/posting_list_decoder.sv */
// Top level of the posting list decoder: byte front end, event queue, field sequencer.
// The decoder takes an encoded posting list byte by byte, together with the number of
// bytes that follow each byte in the buffer, and emits posting records, positions and
// one final ok or error beat per list. The front end assembles each varint in a single
// pass per byte and pushes one event per completed field into a four-entry queue; the
// sequencer retires one event per cycle, while it has room, into a four-entry result
// queue. Input throughput is one byte per cycle while results drain; since the result
// port moves one beat per cycle, runs of bytes that each produce two beats (a position
// that also ends the list, say) stall the input until the result queue has room for two
// beats. Each beat passes the registered event queue, then the registered result queue.
module posting_list_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pld_pkg::pld_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pld_pkg::pld_out_t  out_data_o
);
  import pld_pkg::*;

  logic     tok_push, tok_full, tok_valid, tok_pop;
  pld_tok_t tok_in, tok_out;

  pld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .tok_full_i (tok_full),
    .tok_push_o (tok_push),
    .tok_o      (tok_in)
  );

  pld_tok_fifo u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .valid_o (tok_valid),
    .data_o  (tok_out)
  );

  pld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/tb_posting_list_decoder.sv */
// Self-checking testbench for the posting list decoder: a directed table and random buffers.
`timescale 1ns / 100ps

module tb_posting_list_decoder;
  import pld_pkg::*;

  localparam int RandomBytes = 800;
  localparam int HoldOffAt = 300;
  localparam int HoldOffCycles = 200;

  typedef struct {
    pld_in_t  d;
    bit       typed;
    int       typed_beats;
    pld_out_t typed_beat;
  } stim_t;

  typedef enum int {
    ShapeClean,
    ShapeTruncated,
    ShapeOverlong,
    ShapeCountOver,
    ShapePcountOver,
    ShapeNoise
  } buffer_shape_e;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pld_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  pld_out_t out_data_o;

  posting_list_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Decoder state as the predictor tracks it.
  pld_phase_e  list_phase;
  logic [63:0] varint_acc;
  logic [3:0]  varint_idx;
  logic [23:0] postings_left;
  logic [23:0] positions_left;
  logic [31:0] last_doc;
  logic [31:0] last_pos;
  logic [31:0] held_tf;

  pld_out_t   step_beats[$];
  pld_out_t   expected_beats[$];
  stim_t      stimulus[$];
  stim_t      cur_stim;
  logic [7:0] list_bytes[$];

  pld_out_t want;
  int       mismatches;
  int       beats_checked;
  int       bytes_sent;
  int       random_lists;
  int       clean_lists;
  int       kind_seen[4];
  bit       draining;
  bit       hold_done;

  function automatic pld_out_t status_beat(pld_kind_e k, pld_err_e e);
    pld_out_t r;
    r = '0;
    r.kind = k;
    r.error_code = e;
    return r;
  endfunction

  function automatic void clear_decoder();
    list_phase = PhCount;
    varint_acc = '0;
    varint_idx = '0;
    postings_left = '0;
    positions_left = '0;
    last_doc = '0;
    last_pos = '0;
    held_tf = '0;
  endfunction

  function automatic void emit_record(pld_kind_e k, logic [23:0] count, logic [31:0] pos);
    pld_out_t r;
    r = status_beat(k, ErrNone);
    r.doc_id = last_doc;
    r.term_freq = held_tf;
    r.pos_count = count;
    r.position = pos;
    step_beats.insert(step_beats.size(), r);
  endfunction

  // A list ends with a status beat; the block only rearms when the buffer ends.
  function automatic void close_list(pld_kind_e k, pld_err_e e, logic [23:0] left);
    step_beats.insert(step_beats.size(), status_beat(k, e));
    if (left == 0) clear_decoder();
    else list_phase = PhDone;
  endfunction

  function automatic void decode_byte(pld_in_t d);
    logic [63:0] value;
    logic [23:0] left;
    bit          posting_done;
    left = d.bytes_left;
    posting_done = 1'b0;
    if (list_phase == PhDone) begin
      if (left == 0) clear_decoder();
      return;
    end
    if (varint_idx >= MaxVarintBytes) begin
      close_list(KindError, ErrLong, left);
      return;
    end
    varint_acc = varint_acc | (64'(d.data_byte[6:0]) << (7 * varint_idx));
    if (d.data_byte[MoreBit]) begin
      varint_idx = varint_idx + 1'b1;
      if (left == 0) close_list(KindError, ErrTrunc, left);
      return;
    end
    value = varint_acc;
    varint_acc = '0;
    varint_idx = '0;
    case (list_phase)
      PhCount: begin
        if (value > 64'(left)) begin
          close_list(KindError, ErrCount, left);
          return;
        end
        postings_left = value[23:0];
        last_doc = '0;
        if (value == 0) begin
          close_list(KindOk, ErrNone, left);
          return;
        end
        list_phase = PhDoc;
      end
      PhDoc: begin
        last_doc = last_doc + value[31:0];
        list_phase = PhTf;
      end
      PhTf: begin
        held_tf = value[31:0];
        list_phase = PhPcount;
      end
      PhPcount: begin
        if (value > 64'(left)) begin
          close_list(KindError, ErrCount, left);
          return;
        end
        positions_left = value[23:0];
        last_pos = '0;
        emit_record(KindPosting, value[23:0], '0);
        if (value == 0) posting_done = 1'b1;
        else list_phase = PhPos;
      end
      default: begin
        last_pos = last_pos + value[31:0];
        positions_left = positions_left - 1'b1;
        emit_record(KindPosition, positions_left, last_pos);
        if (positions_left == 0) posting_done = 1'b1;
      end
    endcase
    if (posting_done) begin
      postings_left = postings_left - 1'b1;
      if (postings_left == 0) begin
        close_list(KindOk, ErrNone, left);
        return;
      end
      list_phase = PhDoc;
    end
    if (left == 0) close_list(KindError, ErrTrunc, left);
  endfunction

  task automatic add_row(logic [7:0] b, logic [23:0] left, bit typed, int beats,
                         pld_out_t beat);
    stim_t s;
    s.d.data_byte = b;
    s.d.bytes_left = left;
    s.typed = typed;
    s.typed_beats = beats;
    s.typed_beat = beat;
    stimulus.insert(stimulus.size(), s);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(0, 127));
      4, 5:       return 64'($urandom_range(128, 16383));
      6:          return 64'($urandom);
      7:          return {$urandom, $urandom};
      8:          return 64'hFFFF_FFFF;
      default:    return $urandom_range(0, 1) ? 64'd0 : '1;
    endcase
  endfunction

  // Little-endian base-128; now and then padded with empty groups up to ten bytes.
  task automatic put_varint(logic [63:0] v);
    logic [63:0] rest;
    int          nbytes;
    int          pad;
    rest = v;
    nbytes = 1;
    while (rest[63:7] != 0) begin
      list_bytes.insert(list_bytes.size(), {1'b1, rest[6:0]});
      rest = rest >> 7;
      nbytes++;
    end
    pad = (nbytes < 10 && $urandom_range(0, 9) == 0) ? $urandom_range(1, 10 - nbytes) : 0;
    list_bytes.insert(list_bytes.size(), {pad != 0, rest[6:0]});
    for (int k = 1; k <= pad; k++) list_bytes.insert(list_bytes.size(), {k != pad, 7'h00});
  endtask

  // With pcount_over the last posting claims one position more than the bytes after it.
  task automatic put_postings(int postings, bit pcount_over);
    int  npos;
    bit  over;
    for (int p = 0; p < postings; p++) begin
      over = pcount_over && p == postings - 1;
      put_varint(pick_value());
      put_varint(pick_value());
      npos = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
      put_varint(64'(npos + int'(over)));
      repeat (npos) begin
        if (over) list_bytes.insert(list_bytes.size(), {1'b0, 7'($urandom)});
        else put_varint(pick_value());
      end
    end
  endtask

  task automatic flush_buffer(bit noisy);
    int last;
    last = list_bytes.size() - 1;
    for (int k = 0; k <= last; k++) begin
      if (k == last) add_row(list_bytes[k], '0, 1'b0, 0, '0);
      else if (noisy) add_row(list_bytes[k], 24'($urandom), 1'b0, 0, '0);
      else add_row(list_bytes[k], 24'(last - k), 1'b0, 0, '0);
    end
    list_bytes.delete();
  endtask

  task automatic add_random_buffer();
    buffer_shape_e shape;
    int            pick;
    int            postings;
    int            trail;
    int            cut;
    logic [63:0]   count;
    logic [7:0]    body[$];
    pick = $urandom_range(0, 99);
    if (pick < 55) shape = ShapeClean;
    else if (pick < 65) shape = ShapeTruncated;
    else if (pick < 72) shape = ShapeOverlong;
    else if (pick < 80) shape = ShapeCountOver;
    else if (pick < 88) shape = ShapePcountOver;
    else shape = ShapeNoise;
    random_lists++;
    list_bytes.delete();
    if (shape == ShapeNoise) begin
      repeat ($urandom_range(1, 8)) list_bytes.insert(list_bytes.size(), 8'($urandom));
      flush_buffer(1'b1);
      return;
    end
    if (shape == ShapeClean) clean_lists++;
    postings = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    if (shape == ShapePcountOver && postings == 0) postings = 1;
    put_postings(postings, shape == ShapePcountOver);
    trail = (shape != ShapePcountOver && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (trail) list_bytes.insert(list_bytes.size(), 8'($urandom));
    count = 64'(postings);
    if (shape == ShapeCountOver) begin
      if ($urandom_range(0, 3) == 0) count = {1'b1, 63'($urandom)};
      else count = 64'(list_bytes.size() + 1 + $urandom_range(0, 2));
    end
    body = list_bytes;
    list_bytes.delete();
    put_varint(count);
    foreach (body[k]) list_bytes.insert(list_bytes.size(), body[k]);
    if (shape == ShapeTruncated && list_bytes.size() > 1) begin
      cut = $urandom_range(1, list_bytes.size() - 1);
      while (list_bytes.size() > cut) void'(list_bytes.pop_back());
    end
    if (shape == ShapeOverlong) begin
      cut = $urandom_range(0, list_bytes.size() - 1);
      while (list_bytes.size() > cut) void'(list_bytes.pop_back());
      repeat ($urandom_range(10, 12))
        list_bytes.insert(list_bytes.size(), {1'b1, 7'($urandom)});
      repeat ($urandom_range(1, 3)) list_bytes.insert(list_bytes.size(), 8'($urandom));
    end
    flush_buffer(1'b0);
  endtask

  // Prediction on every accepted byte, checking on every accepted result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_data_i);
        if (cur_stim.typed) begin
          if (cur_stim.typed_beats != 0)
            expected_beats.insert(expected_beats.size(), cur_stim.typed_beat);
        end else begin
          foreach (step_beats[k]) expected_beats.insert(expected_beats.size(), step_beats[k]);
        end
        step_beats.delete();
        bytes_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        beats_checked++;
        kind_seen[out_data_o.kind]++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing pending: kind %0d doc %h pos %h err %0d",
                     $realtime, out_data_o.kind, out_data_o.doc_id, out_data_o.position,
                     out_data_o.error_code);
        end else begin
          want = expected_beats.pop_front();
          if (out_data_o.kind !== want.kind || out_data_o.doc_id !== want.doc_id ||
              out_data_o.term_freq !== want.term_freq ||
              out_data_o.pos_count !== want.pos_count ||
              out_data_o.position !== want.position ||
              out_data_o.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: beat %0d expected/actual: kind %0d/%0d doc %h/%h tf %h/%h",
                     $realtime, beats_checked, want.kind, out_data_o.kind,
                     want.doc_id, out_data_o.doc_id, want.term_freq, out_data_o.term_freq);
              $display(" count %h/%h pos %h/%h err %0d/%0d",
                       want.pos_count, out_data_o.pos_count, want.position,
                       out_data_o.position, want.error_code, out_data_o.error_code);
            end
          end
        end
      end
    end
  end

  // Receiver: random stall patterns that change after each random span, plus one long hold-off
  // that lets the decoder fill up and push back on the byte stream.
  initial begin : receiver
    int stall_mode;
    int span;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      stall_mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk_i);
        if (draining) begin
          out_stall_i = 1'b0;
        end else if (!hold_done && bytes_sent >= HoldOffAt) begin
          hold_done = 1'b1;
          out_stall_i = 1'b1;
          repeat (HoldOffCycles) @(negedge clk_i);
        end else begin
          case (stall_mode)
            0:       out_stall_i = 1'b0;
            1:       out_stall_i = ($urandom_range(0, 3) == 0);
            2:       out_stall_i = ($urandom_range(0, 3) != 0);
            default: out_stall_i = ~out_stall_i;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : sender
    int burst;
    int gap;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    draining = 1'b0;
    hold_done = 1'b0;
    mismatches = 0;
    beats_checked = 0;
    bytes_sent = 0;
    random_lists = 0;
    clean_lists = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    clear_decoder();

    // Directed: single-byte lists, an overlong varint, a short full list, the widest
    // byte count, and a buffer that runs out right after a posting record.
    add_row(8'h00, 24'd0, 1'b1, 1, status_beat(KindOk, ErrNone));
    add_row(8'h05, 24'd0, 1'b1, 1, status_beat(KindError, ErrCount));
    add_row(8'h80, 24'd0, 1'b1, 1, status_beat(KindError, ErrTrunc));
    for (int k = 0; k < 10; k++) add_row(8'hFF, 24'(20 - k), 1'b1, 0, '0);
    add_row(8'h7F, 24'd10, 1'b1, 1, status_beat(KindError, ErrLong));
    add_row(8'hFF, 24'd0, 1'b1, 0, '0);
    add_row(8'h01, 24'd4, 1'b0, 0, '0);
    add_row(8'h7F, 24'd3, 1'b0, 0, '0);
    add_row(8'h00, 24'd2, 1'b0, 0, '0);
    add_row(8'h01, 24'd1, 1'b0, 0, '0);
    add_row(8'h7F, 24'd0, 1'b0, 0, '0);
    add_row(8'h00, 24'hFF_FFFF, 1'b1, 1, status_beat(KindOk, ErrNone));
    add_row(8'hFF, 24'd0, 1'b1, 0, '0);
    add_row(8'h02, 24'd3, 1'b0, 0, '0);
    add_row(8'h00, 24'd2, 1'b0, 0, '0);
    add_row(8'h00, 24'd1, 1'b0, 0, '0);
    add_row(8'h00, 24'd0, 1'b0, 0, '0);
    cur_stim = stimulus[0];
    gap = stimulus.size();
    while (stimulus.size() < gap + RandomBytes) add_random_buffer();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    burst = 0;
    for (int i = 0; i < stimulus.size(); i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      cur_stim = stimulus[i];
      in_data_i = stimulus[i].d;
      in_valid_i = 1'b1;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      burst--;
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    draining = 1'b1;
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes in the directed table and %0d random buffers (%0d clean lists).",
             bytes_sent, random_lists, clean_lists);
    $display("Checked %0d beats: %0d postings, %0d positions, %0d ok, %0d errors; %0d wrong.",
             beats_checked, kind_seen[KindPosting], kind_seen[KindPosition],
             kind_seen[KindOk], kind_seen[KindError], mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
